>>> rtl/cdu_pkg.sv
// Calendar date unit package: request codes, date and pipeline stage types,
// calendar constants and month tables shared by the RTL modules.
// No dependencies.
`default_nettype none

package cdu_pkg;

   // Request codes carried on req_type
   typedef enum logic [1:0] {
      REQ_LOAD_DATE   = 2'd0,
      REQ_LOAD_SERIAL = 2'd1,
      REQ_STEP_FWD    = 2'd2,
      REQ_STEP_BACK   = 2'd3
   } req_code_type;

   // Calendar range and day counts
   localparam int YEAR_FIRST    = 1901;
   localparam int YEAR_LAST     = 2099;
   localparam int SERIAL_LAST   = 72684;
   localparam int DAYS_PER_YEAR = 365;
   localparam int DAYS_PER_QUAD = 1461;
   localparam int WEEK_DAYS     = 7;

   // floor(2^22 / 1461): quotient estimate is low by at most one
   localparam int QUAD_RECIP = 2870;
   localparam int QUAD_SHIFT = 22;

   localparam logic [2:0] WEEKDAY_NONE = 3'd7;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   localparam date_type MARKER_DATE = '{year: 12'd1, month: 4'd1, day: 5'd1};

   // Stage 1: raw request fields
   typedef struct packed {
      req_code_type code;
      logic [11:0]  year;
      logic [3:0]   month;
      logic [4:0]   day;
      logic [16:0]  serial;
   } req_stage_type;

   // Stage 2: request plus estimated four-year block index
   typedef struct packed {
      req_stage_type req;
      logic [6:0]    quad_est;
   } split_stage_type;

   // Stage 3: decoded load candidate
   typedef struct packed {
      req_code_type code;
      logic         ok;
      date_type     date;
   } cand_stage_type;

   // Length of a month; zero for a month code outside 1..12
   function automatic logic [4:0] days_in(input logic [11:0] year, input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Days of the year before the first of a month, leap day included
   function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
      logic [8:0] cnt;
      case (month)
         4'd1:    cnt = 9'd0;
         4'd2:    cnt = 9'd31;
         4'd3:    cnt = 9'd59;
         4'd4:    cnt = 9'd90;
         4'd5:    cnt = 9'd120;
         4'd6:    cnt = 9'd151;
         4'd7:    cnt = 9'd181;
         4'd8:    cnt = 9'd212;
         4'd9:    cnt = 9'd243;
         4'd10:   cnt = 9'd273;
         4'd11:   cnt = 9'd304;
         4'd12:   cnt = 9'd334;
         default: cnt = 9'd0;
      endcase
      if (leap && (month > 4'd2)) begin
         cnt = cnt + 9'd1;
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cdu_decode.sv
// Calendar date unit decode stage: checks a load-date request and converts
// a serial day number into year/month/day. Uses cdu_pkg.
`default_nettype none

module cdu_decode (
   input  cdu_pkg::split_stage_type split_stage,
   output cdu_pkg::cand_stage_type  cand_stage
);
   import cdu_pkg::*;

   logic [16:0] day_index;
   logic [17:0] quad_prod;
   logic [16:0] quad_rest;
   logic [6:0]  quad;
   logic [10:0] quad_rem;
   logic [1:0]  year_in_quad;
   logic [10:0] year_days;
   logic [8:0]  year_rem;
   logic        leap;
   logic [3:0]  conv_month;
   logic [8:0]  month_start;
   date_type    conv_date;
   logic        load_ok;
   logic        serial_ok;

   // Fix the block estimate: remainder within one block
   always_comb begin
      day_index = split_stage.req.serial - 17'd1;
      quad_prod = 18'(split_stage.quad_est) * 18'(DAYS_PER_QUAD);
      quad_rest = day_index - quad_prod[16:0];
      if (quad_rest >= 17'(DAYS_PER_QUAD)) begin
         quad     = split_stage.quad_est + 7'd1;
         quad_rem = 11'(quad_rest - 17'(DAYS_PER_QUAD));
      end else begin
         quad     = split_stage.quad_est;
         quad_rem = quad_rest[10:0];
      end
   end

   // Year within the block; the fourth year is the leap year
   always_comb begin
      if (quad_rem >= 11'(3 * DAYS_PER_YEAR)) begin
         year_in_quad = 2'd3;
         year_days    = 11'(3 * DAYS_PER_YEAR);
      end else if (quad_rem >= 11'(2 * DAYS_PER_YEAR)) begin
         year_in_quad = 2'd2;
         year_days    = 11'(2 * DAYS_PER_YEAR);
      end else if (quad_rem >= 11'(DAYS_PER_YEAR)) begin
         year_in_quad = 2'd1;
         year_days    = 11'(DAYS_PER_YEAR);
      end else begin
         year_in_quad = 2'd0;
         year_days    = 11'd0;
      end
      year_rem = 9'(quad_rem - year_days);
      leap     = (year_in_quad == 2'd3);
   end

   // Month by parallel compares against month starts
   always_comb begin
      conv_month = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (year_rem >= days_before(4'(m), leap)) begin
            conv_month = 4'(m);
         end
      end
      month_start     = days_before(conv_month, leap);
      conv_date.year  = 12'(YEAR_FIRST) + {3'b000, quad, 2'b00} + {10'd0, year_in_quad};
      conv_date.month = conv_month;
      conv_date.day   = 5'(year_rem - month_start + 9'd1);
   end

   // Range checks
   always_comb begin
      load_ok = (split_stage.req.year >= 12'(YEAR_FIRST))
             && (split_stage.req.year <= 12'(YEAR_LAST))
             && (split_stage.req.month >= 4'd1) && (split_stage.req.month <= 4'd12)
             && (split_stage.req.day >= 5'd1)
             && (split_stage.req.day <= days_in(split_stage.req.year, split_stage.req.month));
      serial_ok = (split_stage.req.serial != 17'd0)
               && (split_stage.req.serial <= 17'(SERIAL_LAST));
   end

   // Candidate for the state update
   always_comb begin
      cand_stage.code = split_stage.req.code;
      if (split_stage.req.code == REQ_LOAD_DATE) begin
         cand_stage.ok         = load_ok;
         cand_stage.date.year  = split_stage.req.year;
         cand_stage.date.month = split_stage.req.month;
         cand_stage.date.day   = split_stage.req.day;
      end else begin
         cand_stage.ok   = serial_ok;
         cand_stage.date = conv_date;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cdu_step.sv
// Calendar date unit state update: applies a load, a forward step or a
// back step to the current date. Uses cdu_pkg.
`default_nettype none

module cdu_step (
   input  cdu_pkg::cand_stage_type cand_stage,
   input  cdu_pkg::date_type       cur_date,
   input  logic                    cur_valid,
   output cdu_pkg::date_type       next_date,
   output logic                    next_valid
);
   import cdu_pkg::*;

   logic [4:0] month_len;
   logic [4:0] prev_month_len;

   assign month_len      = days_in(cur_date.year, cur_date.month);
   assign prev_month_len = days_in(cur_date.year, cur_date.month - 4'd1);

   // Next date; the marker covers every invalid outcome
   always_comb begin
      next_date  = MARKER_DATE;
      next_valid = 1'b0;
      case (cand_stage.code)
         REQ_LOAD_DATE, REQ_LOAD_SERIAL: begin
            if (cand_stage.ok) begin
               next_date  = cand_stage.date;
               next_valid = 1'b1;
            end
         end
         REQ_STEP_FWD: begin
            if (cur_valid) begin
               next_date  = cur_date;
               next_valid = 1'b1;
               if (cur_date.day >= month_len) begin
                  next_date.day = 5'd1;
                  if (cur_date.month >= 4'd12) begin
                     next_date.month = 4'd1;
                     if (cur_date.year >= 12'(YEAR_LAST)) begin
                        next_date  = MARKER_DATE;
                        next_valid = 1'b0;
                     end else begin
                        next_date.year = cur_date.year + 12'd1;
                     end
                  end else begin
                     next_date.month = cur_date.month + 4'd1;
                  end
               end else begin
                  next_date.day = cur_date.day + 5'd1;
               end
            end
         end
         REQ_STEP_BACK: begin
            if (cur_valid) begin
               next_date  = cur_date;
               next_valid = 1'b1;
               if (cur_date.day <= 5'd1) begin
                  if (cur_date.month <= 4'd1) begin
                     if (cur_date.year <= 12'(YEAR_FIRST)) begin
                        next_date  = MARKER_DATE;
                        next_valid = 1'b0;
                     end else begin
                        next_date.year  = cur_date.year - 12'd1;
                        next_date.month = 4'd12;
                        next_date.day   = 5'd31;
                     end
                  end else begin
                     next_date.month = cur_date.month - 4'd1;
                     next_date.day   = prev_month_len;
                  end
               end else begin
                  next_date.day = cur_date.day - 5'd1;
               end
            end
         end
         default: begin
            next_date  = MARKER_DATE;
            next_valid = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/cdu_serial.sv
// Calendar date unit output stage: serial day number and weekday of the
// current date. Uses cdu_pkg.
`default_nettype none

module cdu_serial (
   input  cdu_pkg::date_type date,
   input  logic              date_valid,
   output logic [16:0]       serial,
   output logic [2:0]        weekday
);
   import cdu_pkg::*;

   logic [7:0]  year_off;
   logic        leap;
   logic [8:0]  day_of_year;
   logic [16:0] serial_sum;
   logic [9:0]  week_sum;
   logic [4:0]  fold_hi;
   logic [3:0]  fold_lo;
   logic [2:0]  week_rem;

   // Serial: 365 per year plus one per leap year passed
   always_comb begin
      year_off    = 8'(date.year - 12'(YEAR_FIRST));
      leap        = (date.year[1:0] == 2'b00);
      day_of_year = days_before(date.month, leap);
      serial_sum  = 17'(year_off) * 17'(DAYS_PER_YEAR) + 17'(year_off[7:2])
                  + 17'(day_of_year) + 17'(date.day);
   end

   // Weekday: 365 = 1 mod 7, then fold octal digits (8 = 1 mod 7)
   always_comb begin
      week_sum = 10'(year_off) + 10'(year_off[7:2]) + 10'(day_of_year) + 10'(date.day);
      fold_hi  = 5'(week_sum[2:0]) + 5'(week_sum[5:3]) + 5'(week_sum[8:6])
               + 5'(week_sum[9]);
      fold_lo  = 4'(fold_hi[2:0]) + 4'(fold_hi[4:3]);
      if (fold_lo >= 4'(WEEK_DAYS)) begin
         week_rem = 3'(fold_lo - 4'(WEEK_DAYS));
      end else begin
         week_rem = fold_lo[2:0];
      end
   end

   assign serial  = date_valid ? serial_sum : 17'd0;
   assign weekday = date_valid ? week_rem : WEEKDAY_NONE;

endmodule

`default_nettype wire

>>> rtl/calendar_date_unit.sv
// Calendar date unit top level: request pipeline, current-date register and
// result register. Uses cdu_pkg, cdu_decode, cdu_step and cdu_serial.
//
// Usage:
//  The block holds one current date in 1901..2099. Each request transaction
//  on the req_ channel (valid/ready) loads a date, loads a serial day number,
//  or steps the date forward or back one day. Every request yields exactly
//  one result transaction on the rsp_ channel with the date after the
//  request, a valid flag, the serial day number and the weekday.
//  Throughput: one request per cycle unless a low rsp_ready stalls the
//  pipeline. The pipeline is input register, serial block estimate,
//  decode, date update, result register; the date register is the only loop.
//  Reset: all stages empty, the current date becomes the invalid marker
//  1/1/1 (serial 0, weekday 7).
//  Stall: when rsp_ready is low the result holds; empty stages still take
//  requests until the pipeline fills, then req_ready drops.
`default_nettype none

module calendar_date_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [16:0] req_serial_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic        rsp_date_valid,
   output logic [16:0] rsp_serial_out,
   output logic [2:0]  rsp_weekday
);
   import cdu_pkg::*;

   logic            adv1, adv2, adv3, adv4, adv5;
   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   req_stage_type   s1_ff, s1_in;
   split_stage_type s2_ff, s2_in;
   cand_stage_type  s3_ff, s3_in;
   date_type        cur_date_ff, cur_date_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [16:0]     day_index;
   logic [28:0]     quad_prod_est;
   logic [16:0]     serial_in;
   logic [2:0]      weekday_in;
   logic [11:0]     rsp_year_ff;
   logic [3:0]      rsp_month_ff;
   logic [4:0]      rsp_day_ff;
   logic            rsp_date_valid_ff;
   logic [16:0]     rsp_serial_ff;
   logic [2:0]      rsp_weekday_ff;

   // Stage advance: a stage moves when empty or when the next one moves
   assign adv5      = !rsp_valid_ff || rsp_ready;
   assign adv4      = !s4_valid_ff || adv5;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   // Stage 1 capture
   always_comb begin
      s1_in.code   = req_code_type'(req_type);
      s1_in.year   = req_year_in;
      s1_in.month  = req_month_in;
      s1_in.day    = req_day_in;
      s1_in.serial = req_serial_in;
   end

   // Four-year block estimate by reciprocal multiply
   always_comb begin
      day_index      = s1_ff.serial - 17'd1;
      quad_prod_est  = 29'(day_index) * 29'(QUAD_RECIP);
      s2_in.req      = s1_ff;
      s2_in.quad_est = quad_prod_est[QUAD_SHIFT +: 7];
   end

   cdu_decode u_decode (
      .split_stage (s2_ff),
      .cand_stage  (s3_in)
   );

   cdu_step u_step (
      .cand_stage (s3_ff),
      .cur_date   (cur_date_ff),
      .cur_valid  (cur_valid_ff),
      .next_date  (cur_date_in),
      .next_valid (cur_valid_in)
   );

   cdu_serial u_serial (
      .date       (cur_date_ff),
      .date_valid (cur_valid_ff),
      .serial     (serial_in),
      .weekday    (weekday_in)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_date_ff  <= MARKER_DATE;
         cur_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff  <= req_valid;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) s3_valid_ff  <= s2_valid_ff;
         if (adv4) s4_valid_ff  <= s3_valid_ff;
         if (adv5) rsp_valid_ff <= s4_valid_ff;
         // Date register updates once per request transaction
         if (adv4 && s3_valid_ff) begin
            cur_date_ff  <= cur_date_in;
            cur_valid_ff <= cur_valid_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv1 && req_valid)   s1_ff <= s1_in;
      if (adv2 && s1_valid_ff) s2_ff <= s2_in;
      if (adv3 && s2_valid_ff) s3_ff <= s3_in;
      if (adv5 && s4_valid_ff) begin
         rsp_year_ff       <= cur_date_ff.year;
         rsp_month_ff      <= cur_date_ff.month;
         rsp_day_ff        <= cur_date_ff.day;
         rsp_date_valid_ff <= cur_valid_ff;
         rsp_serial_ff     <= serial_in;
         rsp_weekday_ff    <= weekday_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_year_out   = rsp_year_ff;
   assign rsp_month_out  = rsp_month_ff;
   assign rsp_day_out    = rsp_day_ff;
   assign rsp_date_valid = rsp_date_valid_ff;
   assign rsp_serial_out = rsp_serial_ff;
   assign rsp_weekday    = rsp_weekday_ff;

   // An invalid current date is always the marker
   a_marker_when_invalid: assert property (@(posedge clock) disable iff (reset)
      !cur_valid_ff |-> (cur_date_ff == MARKER_DATE))
      else $error("invalid date is not the marker");

   // A valid current date lies in range
   a_valid_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ((cur_date_ff.year >= 12'(YEAR_FIRST))
                     && (cur_date_ff.year <= 12'(YEAR_LAST))
                     && (cur_date_ff.month >= 4'd1) && (cur_date_ff.month <= 4'd12)
                     && (cur_date_ff.day >= 5'd1)))
      else $error("valid date out of range");

   // Date register changes only on an update transfer
   a_date_hold: assert property (@(posedge clock) disable iff (reset)
      !(adv4 && s3_valid_ff) |=> ($stable(cur_date_ff) && $stable(cur_valid_ff)))
      else $error("date changed without an update");

   // A valid result never carries the no-weekday code
   a_weekday_known: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_date_valid_ff) |-> (rsp_weekday_ff != WEEKDAY_NONE))
      else $error("valid date without weekday");

   // An accepted request enters stage 1
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request lost");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for calendar_date_unit: directed and random date loads, serial loads
// and day steps, checked against a behavioral date model kept in this file.
// Depends on rtl/cdu_pkg.sv and rtl/calendar_date_unit.sv.
`timescale 1ns / 100ps

module tb;
   import cdu_pkg::*;

   // One expected response transaction
   typedef struct packed {
      date_type    date;
      logic        ok;
      logic [16:0] serial;
      logic [2:0]  weekday;
   } date_report_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [11:0] req_year_in;
   logic [3:0]  req_month_in;
   logic [4:0]  req_day_in;
   logic [16:0] req_serial_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic        rsp_date_valid;
   logic [16:0] rsp_serial_out;
   logic [2:0]  rsp_weekday;

   // Model state and scoreboard
   date_type        cal_now;
   date_report_type reports_due[$];
   bit              send_idle;
   bit              recv_idle;
   int              mismatch_count;
   int              items_sent;
   int              steps_sent;
   int              results_seen;
   int              invalid_seen;

   calendar_date_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_year_in    (req_year_in),
      .req_month_in   (req_month_in),
      .req_day_in     (req_day_in),
      .req_serial_in  (req_serial_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_date_valid (rsp_date_valid),
      .rsp_serial_out (rsp_serial_out),
      .rsp_weekday    (rsp_weekday)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Date model
   // ---------------------------------------------------------------------

   // Month length, 0 for a bad month; every fourth year is leap in range
   function automatic int month_days(input int year, input int month);
      int len;
      case (month)
         2:                       len = (year % 4 == 0) ? 29 : 28;
         4, 6, 9, 11:             len = 30;
         1, 3, 5, 7, 8, 10, 12:   len = 31;
         default:                 len = 0;
      endcase
      return len;
   endfunction

   function automatic bit date_is_real(input int year, input int month, input int day);
      return year >= YEAR_FIRST && year <= YEAR_LAST && day >= 1 &&
             day <= month_days(year, month);
   endfunction

   // Days since 31 Dec 1900
   function automatic int day_number(input int year, input int month, input int day);
      int total;
      int m;
      total = (year - YEAR_FIRST) * 365 + (year - YEAR_FIRST) / 4;
      for (m = 1; m < month; m++) begin
         total += month_days(year, m);
      end
      return total + day;
   endfunction

   // Walk years then months; caller guarantees 1..SERIAL_LAST
   function automatic date_type date_of_day_number(input int serial);
      int       rest;
      int       y;
      int       m;
      date_type d;
      rest = serial - 1;
      y = YEAR_FIRST;
      while (rest >= ((y % 4 == 0) ? 366 : 365)) begin
         rest -= (y % 4 == 0) ? 366 : 365;
         y++;
      end
      m = 1;
      while (rest >= month_days(y, m)) begin
         rest -= month_days(y, m);
         m++;
      end
      d.year  = 12'(y);
      d.month = 4'(m);
      d.day   = 5'(rest + 1);
      return d;
   endfunction

   // Update the model date for one request and build its response
   function automatic date_report_type apply_request(input req_code_type code,
                                                     input int year, input int month,
                                                     input int day, input int serial);
      date_type        nxt;
      date_report_type rpt;
      int              num;
      nxt = cal_now;
      if (code == REQ_LOAD_DATE) begin
         if (date_is_real(year, month, day)) begin
            nxt.year  = 12'(year);
            nxt.month = 4'(month);
            nxt.day   = 5'(day);
         end else begin
            nxt = MARKER_DATE;
         end
      end else if (code == REQ_LOAD_SERIAL) begin
         nxt = (serial >= 1 && serial <= SERIAL_LAST) ? date_of_day_number(serial)
                                                       : MARKER_DATE;
      end else if (!date_is_real(cal_now.year, cal_now.month, cal_now.day)) begin
         nxt = MARKER_DATE;
      end else if (code == REQ_STEP_FWD) begin
         if (cal_now.day < month_days(cal_now.year, cal_now.month)) begin
            nxt.day = cal_now.day + 5'd1;
         end else if (cal_now.month < 4'd12) begin
            nxt.month = cal_now.month + 4'd1;
            nxt.day   = 5'd1;
         end else if (cal_now.year < YEAR_LAST) begin
            nxt.year  = cal_now.year + 12'd1;
            nxt.month = 4'd1;
            nxt.day   = 5'd1;
         end else begin
            nxt = MARKER_DATE;
         end
      end else begin
         if (cal_now.day > 5'd1) begin
            nxt.day = cal_now.day - 5'd1;
         end else if (cal_now.month > 4'd1) begin
            nxt.month = cal_now.month - 4'd1;
            nxt.day   = 5'(month_days(cal_now.year, cal_now.month - 1));
         end else if (cal_now.year > YEAR_FIRST) begin
            nxt.year  = cal_now.year - 12'd1;
            nxt.month = 4'd12;
            nxt.day   = 5'd31;
         end else begin
            nxt = MARKER_DATE;
         end
      end
      cal_now = nxt;

      // Marker date reports serial 0 and no weekday
      rpt.date = nxt;
      if (date_is_real(nxt.year, nxt.month, nxt.day)) begin
         num         = day_number(nxt.year, nxt.month, nxt.day);
         rpt.ok      = 1'b1;
         rpt.serial  = 17'(num);
         rpt.weekday = 3'(num % 7);
      end else begin
         rpt.date    = MARKER_DATE;
         rpt.ok      = 1'b0;
         rpt.serial  = 17'd0;
         rpt.weekday = WEEKDAY_NONE;
      end
      return rpt;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Send one request transaction; called at a falling edge, returns at one
   task automatic send_request(input req_code_type code, input int year, input int month,
                               input int day, input int serial);
      int gap;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_type      = code;
      req_year_in   = 12'(year);
      req_month_in  = 4'(month);
      req_day_in    = 5'(day);
      req_serial_in = 17'(serial);
      do @(posedge clock); while (!req_ready);
      reports_due.push_back(apply_request(code, req_year_in, req_month_in, req_day_in,
                                          req_serial_in));
      items_sent++;
      if (code == REQ_STEP_FWD || code == REQ_STEP_BACK) begin
         steps_sent++;
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Hold off until every outstanding response has arrived
   task automatic wait_results_drained();
      while (reports_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Receiver: random stall before each response transaction
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(0, 17) : 0;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      date_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (reports_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d valid %0b",
                     $time, rsp_year_out, rsp_month_out, rsp_day_out, rsp_date_valid);
         end else begin
            want = reports_due.pop_front();
            check_field("year", want.date.year, rsp_year_out);
            check_field("month", want.date.month, rsp_month_out);
            check_field("day", want.date.day, rsp_day_out);
            check_field("date_valid", want.ok, rsp_date_valid);
            check_field("serial", want.serial, rsp_serial_out);
            check_field("weekday", want.weekday, rsp_weekday);
            if (!want.ok) begin
               invalid_seen++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Range limits, leap day, and malformed dates (all-ones and all-zero fields)
   task automatic test_load_date_checks();
      send_request(REQ_LOAD_DATE, 1901, 1, 1, 0);
      send_request(REQ_LOAD_DATE, 2099, 12, 31, 0);
      send_request(REQ_LOAD_DATE, 2000, 2, 29, 0);
      send_request(REQ_LOAD_DATE, 1901, 2, 29, 0);
      send_request(REQ_LOAD_DATE, 2100, 1, 1, 0);
      send_request(REQ_LOAD_DATE, 4095, 15, 31, 0);
      send_request(REQ_LOAD_DATE, 0, 0, 0, 0);
      send_request(REQ_LOAD_DATE, 2024, 4, 31, 0);
      send_request(REQ_LOAD_DATE, 2024, 13, 0, 0);
   endtask

   // Serial bounds, then stepping off the last day and stepping the marker
   task automatic test_load_serial_bounds();
      send_request(REQ_LOAD_SERIAL, 0, 0, 0, 0);
      send_request(REQ_LOAD_SERIAL, 0, 0, 0, 1);
      send_request(REQ_LOAD_SERIAL, 0, 0, 0, 131071);
      send_request(REQ_LOAD_SERIAL, 0, 0, 0, SERIAL_LAST + 1);
      send_request(REQ_LOAD_SERIAL, 0, 0, 0, SERIAL_LAST);
      send_request(REQ_STEP_FWD, 0, 0, 0, 0);
      send_request(REQ_STEP_FWD, 0, 0, 0, 0);
      send_request(REQ_STEP_BACK, 0, 0, 0, 0);
   endtask

   // Stepping before the first day, across leap February and a year turn
   task automatic test_leap_and_year_turns();
      send_request(REQ_LOAD_DATE, 1901, 1, 1, 0);
      send_request(REQ_STEP_BACK, 0, 0, 0, 0);
      send_request(REQ_LOAD_DATE, 2004, 2, 28, 0);
      send_request(REQ_STEP_FWD, 0, 0, 0, 0);
      send_request(REQ_STEP_FWD, 0, 0, 0, 0);
      send_request(REQ_STEP_BACK, 0, 0, 0, 0);
      send_request(REQ_LOAD_DATE, 2003, 12, 31, 0);
      send_request(REQ_STEP_FWD, 0, 0, 0, 0);
      send_request(REQ_STEP_BACK, 0, 0, 0, 0);
   endtask

   // Load a real date, then walk it a random number of days
   task automatic test_random_walks(input int count);
      int last;
      int y;
      int m;
      int d;
      int steps;
      bit lean_fwd;
      last = items_sent + count;
      while (items_sent < last) begin
         send_idle = $urandom_range(0, 3) != 0;
         recv_idle = $urandom_range(0, 3) != 0;
         y = $urandom_range(YEAR_FIRST, YEAR_LAST);
         m = $urandom_range(1, 12);
         d = $urandom_range(1, month_days(y, m));
         case ($urandom_range(0, 5))
            0: begin
               y = YEAR_LAST;
               m = 12;
               d = $urandom_range(22, 31);
            end
            1: begin
               y = YEAR_FIRST;
               m = 1;
               d = $urandom_range(1, 10);
            end
            2: d = month_days(y, m) - $urandom_range(0, 2);
            3: begin
               y = 4 * $urandom_range(476, 524);
               m = $urandom_range(2, 3);
               d = (m == 2) ? $urandom_range(27, 29) : 1;
            end
            default: ;
         endcase
         if ($urandom_range(0, 4) == 0) begin
            send_request(REQ_LOAD_SERIAL, 0, 0, 0, day_number(y, m, d));
         end else begin
            send_request(REQ_LOAD_DATE, y, m, d, 0);
         end
         lean_fwd = $urandom_range(0, 1);
         steps = $urandom_range(1, 20);
         repeat (steps) begin
            if (($urandom_range(0, 9) < 8) == lean_fwd) begin
               send_request(REQ_STEP_FWD, $urandom, $urandom, $urandom, $urandom);
            end else begin
               send_request(REQ_STEP_BACK, $urandom, $urandom, $urandom, $urandom);
            end
         end
      end
   endtask

   // Unconstrained requests, with some near the range limits
   task automatic test_random_noise(input int count);
      int y;
      int s;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (count) begin
         y = ($urandom_range(0, 2) == 0) ? $urandom_range(YEAR_FIRST - 2, YEAR_LAST + 2)
                                         : $urandom_range(0, 4095);
         s = ($urandom_range(0, 2) == 0) ? $urandom_range(SERIAL_LAST - 3, SERIAL_LAST + 3)
                                         : $urandom_range(0, 131071);
         send_request(req_code_type'(2'($urandom_range(0, 3))), y, $urandom_range(0, 15),
                      $urandom_range(0, 31), s);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_LOAD_DATE;
      req_year_in    = 12'd0;
      req_month_in   = 4'd0;
      req_day_in     = 5'd0;
      req_serial_in  = 17'd0;
      send_idle      = 1'b1;
      recv_idle      = 1'b1;
      mismatch_count = 0;
      items_sent     = 0;
      steps_sent     = 0;
      results_seen   = 0;
      invalid_seen   = 0;
      cal_now        = MARKER_DATE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_date_checks();
      test_load_serial_bounds();
      test_leap_and_year_turns();
      wait_results_drained();
      test_random_walks(400);
      wait_results_drained();
      test_random_noise(100);

      // Let any stray response show up after the last expected one
      wait_results_drained();
      repeat (20) @(posedge clock);

      $display("Sent %0d requests (%0d day steps); checked %0d responses, %0d invalid dates.",
               items_sent, steps_sent, results_seen, invalid_seen);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses outstanding.", reports_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
